// ----- design/pfa_pkg.sv -----
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int OP_W       = 1;
    localparam int BIDX_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int POLICY_W   = 2;
    localparam int BCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int PTR_W      = 4;

    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } pfa_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic finish;
    } pfa_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } pfa_status_t;

endpackage

// ----- design/partition_fit_allocator_top.sv -----
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid / in_stall        operation, block_index, size_value
// output    out_valid / out_stall      granted, chosen_block, capacity_before
// config    cfg_wr_en                  cfg_index, cfg_data
//
// A load transfer does not leave the idle state, so the block is ready again in the next cycle.
// A request scans min(block_count, MAX_BLOCKS) blocks: one table read per scan cycle.
// The next input transfer is taken while a result waits; a request holds in its last
// cycle only while the previous result is still stalled.
// Reset restores the policy, block count, next-fit pointer and handshake state; the
// capacity table is not cleared and is defined only once loaded.

module partition_fit_allocator_top
    import pfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [BIDX_W-1:0]     block_index,
    input  logic [SIZE_W-1:0]     size_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  granted,
    output logic [BIDX_W-1:0]     chosen_block,
    output logic [SIZE_W-1:0]     capacity_before,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pfa_cmd_t    cmd;
    pfa_status_t status;

    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .status    (status)
    );

    pfa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .block_index     (block_index),
        .size_value      (size_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted         (granted),
        .chosen_block    (chosen_block),
        .capacity_before (capacity_before)
    );

endmodule

// ----- design/pfa_ctrl.sv -----
`timescale 1ns / 1ps

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [OP_W-1:0]   operation,
    output logic              in_stall,
    output pfa_cmd_t          cmd,
    input  pfa_status_t       status
);

    pfa_state_t state_reg;
    pfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (operation == OP_REQUEST))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.load  = in_valid && (operation == OP_LOAD);
                cmd.start = in_valid && (operation == OP_REQUEST);
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !status.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- design/pfa_datapath.sv -----
`timescale 1ns / 1ps

module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfa_cmd_t              cmd,
    output pfa_status_t           status,
    input  logic [BIDX_W-1:0]     block_index,
    input  logic [SIZE_W-1:0]     size_value,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  granted,
    output logic [BIDX_W-1:0]     chosen_block,
    output logic [SIZE_W-1:0]     capacity_before
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [SIZE_BITS-1:0] mem_array [MAX_BLOCKS];

    logic [POLICY_W-1:0]  policy_reg, policy_next;
    logic [BCOUNT_W-1:0]  bcount_reg, bcount_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     issue_left_reg, issue_left_next;
    logic [IDX_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [SIZE_BITS-1:0] req_size_reg, req_size_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     pick_idx_reg, pick_idx_next;
    logic [SIZE_BITS-1:0] pick_cap_reg, pick_cap_next;
    logic                 granted_reg, granted_next;
    logic [BIDX_W-1:0]    chosen_reg, chosen_next;
    logic [SIZE_W-1:0]    cap_before_reg, cap_before_next;
    logic [SIZE_BITS-1:0] rd_data_reg;

    logic [31:0]          size_wide;
    logic [SIZE_BITS-1:0] size_cap;
    logic [CNT_W-1:0]     eff_cnt;
    logic [IDX_W-1:0]     start_idx;
    logic [CNT_W-1:0]     issue_inc;
    logic [IDX_W-1:0]     inc_idx;
    logic                 load_ok;
    logic                 take;
    logic [31:0]          pick_idx_wide;
    logic [31:0]          pick_cap_wide;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    assign size_wide     = 32'(size_value);
    assign size_cap      = size_wide[SIZE_BITS-1:0];
    assign eff_cnt       = (32'(bcount_reg) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : CNT_W'(bcount_reg);
    assign start_idx     = ((policy_reg == POL_NEXT) && (32'(ptr_reg) < 32'(eff_cnt)))
                           ? IDX_W'(ptr_reg) : '0;
    assign issue_inc     = CNT_W'(issue_idx_reg) + CNT_W'(1);
    assign inc_idx       = (issue_inc == cnt_reg) ? '0 : IDX_W'(issue_inc);
    assign load_ok       = cmd.load && (32'(block_index) < 32'(MAX_BLOCKS));
    assign pick_idx_wide = 32'(pick_idx_reg);
    assign pick_cap_wide = 32'(pick_cap_reg);

    assign take = (rd_data_reg >= req_size_reg)
                  && (!found_reg
                      || ((policy_reg == POL_BEST) && (rd_data_reg < pick_cap_reg))
                      || ((policy_reg == POL_WORST) && (rd_data_reg > pick_cap_reg)));

    assign wr_en   = load_ok || (cmd.finish && found_reg);
    assign wr_addr = load_ok ? IDX_W'(block_index) : pick_idx_reg;
    assign wr_data = load_ok ? size_cap : (pick_cap_reg - req_size_reg);

    assign status.scan_done = (issue_left_reg == '0) && (rd_valid_reg || (cnt_reg == '0));
    assign status.out_busy  = out_valid_reg && out_stall;

    assign out_valid       = out_valid_reg;
    assign granted         = granted_reg;
    assign chosen_block    = chosen_reg;
    assign capacity_before = cap_before_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[issue_idx_reg];
    end

    always_comb
    begin
        policy_next     = policy_reg;
        bcount_next     = bcount_reg;
        ptr_next        = ptr_reg;
        found_next      = found_reg;
        issue_left_next = issue_left_reg;
        issue_idx_next  = issue_idx_reg;
        rd_valid_next   = cmd.scan && (issue_left_reg != '0);
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        req_size_next   = req_size_reg;
        rd_idx_next     = issue_idx_reg;
        pick_idx_next   = pick_idx_reg;
        pick_cap_next   = pick_cap_reg;
        granted_next    = granted_reg;
        chosen_next     = chosen_reg;
        cap_before_next = cap_before_reg;

        if (cfg_wr_en && (cfg_index == REG_FIT_POLICY))
        begin
            policy_next = cfg_data[POLICY_W-1:0];
        end
        if (cfg_wr_en && (cfg_index == REG_BLOCK_COUNT))
        begin
            bcount_next = cfg_data[BCOUNT_W-1:0];
        end

        if (cmd.load)
        begin
            ptr_next = '0;
        end

        if (cmd.start)
        begin
            req_size_next   = size_cap;
            cnt_next        = eff_cnt;
            issue_left_next = eff_cnt;
            issue_idx_next  = start_idx;
            found_next      = 1'b0;
        end

        if (cmd.scan && (issue_left_reg != '0))
        begin
            issue_left_next = issue_left_reg - CNT_W'(1);
            issue_idx_next  = inc_idx;
        end

        if (rd_valid_reg && take)
        begin
            found_next    = 1'b1;
            pick_idx_next = rd_idx_reg;
            pick_cap_next = rd_data_reg;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            granted_next    = found_reg;
            chosen_next     = found_reg ? pick_idx_wide[BIDX_W-1:0] : '0;
            cap_before_next = found_reg ? pick_cap_wide[SIZE_W-1:0] : '0;
            if (found_reg && (policy_reg == POL_NEXT))
            begin
                ptr_next = pick_idx_wide[PTR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= POL_FIRST;
            bcount_reg     <= BCOUNT_W'(16);
            ptr_reg        <= '0;
            found_reg      <= 1'b0;
            issue_left_reg <= '0;
            issue_idx_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            policy_reg     <= policy_next;
            bcount_reg     <= bcount_next;
            ptr_reg        <= ptr_next;
            found_reg      <= found_next;
            issue_left_reg <= issue_left_next;
            issue_idx_reg  <= issue_idx_next;
            rd_valid_reg   <= rd_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_size_reg   <= req_size_next;
        rd_idx_reg     <= rd_idx_next;
        pick_idx_reg   <= pick_idx_next;
        pick_cap_reg   <= pick_cap_next;
        granted_reg    <= granted_next;
        chosen_reg     <= chosen_next;
        cap_before_reg <= cap_before_next;
    end

    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        issue_left_reg <= cnt_reg)
        else $error("More reads left to issue than blocks in use.");

    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (pick_cap_reg >= req_size_reg))
        else $error("Chosen block is smaller than the request.");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (32'(pick_idx_reg) < 32'(cnt_reg)))
        else $error("Chosen block lies beyond the blocks in use.");

    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("Finished request did not produce a result transfer.");

endmodule
